// ----- design/stq_pkg.sv -----
// Shared types, constants and codes of the sorted timer queue.
package stq_pkg;

   localparam int ID_W = 4;
   localparam int EXP_W = 32;
   localparam int OFS_W = 24;
   localparam int MAX_QDEPTH = 2 ** ID_W;
   localparam int NUM_TIMERS_DEF = 16;
   localparam int TICKS_PER_SEC = 100;

   localparam logic [1:0] OP_SET = 2'd0;
   localparam logic [1:0] OP_DEL = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [ID_W-1:0]  timer_id;
      logic [EXP_W-1:0] expires;
      logic [EXP_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic            was_pending;
      logic            fired_valid;
      logic [ID_W-1:0] fired_id;
      logic            last;
   } rsp_type;

   typedef enum logic [1:0] {
      QOP_NONE,
      QOP_INSERT,
      QOP_REMOVE
   } qop_type;

   typedef struct packed {
      qop_type          op;
      logic [ID_W-1:0]  id;
      logic [EXP_W-1:0] expiry;
   } qcmd_type;

   typedef struct packed {
      logic [EXP_W-1:0] a;
      logic [EXP_W-1:0] b;
      logic             sub;
   } alu_req_type;

   typedef struct packed {
      logic [EXP_W-1:0] sum;
      logic             carry;
      logic             zero;
   } alu_rsp_type;

endpackage

// ----- design/stq_alu.sv -----
// Shared 32-bit adder and comparator used by the compare and sum steps of the sequencer.
module stq_alu (
   input  stq_pkg::alu_req_type alu_req,
   output stq_pkg::alu_rsp_type alu_rsp
);

   logic [stq_pkg::EXP_W:0]   full_sum;
   logic [stq_pkg::EXP_W-1:0] b_eff;

   // Subtraction is a plus the inverted b plus one; carry set means no borrow.
   assign b_eff = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign full_sum = {1'b0, alu_req.a} + {1'b0, b_eff}
                     + {{stq_pkg::EXP_W{1'b0}}, alu_req.sub};

   assign alu_rsp.sum = full_sum[stq_pkg::EXP_W-1:0];
   assign alu_rsp.carry = full_sum[stq_pkg::EXP_W];
   assign alu_rsp.zero = (full_sum[stq_pkg::EXP_W-1:0] == '0);

endmodule

// ----- design/stq_queue.sv -----
// Sorted entry row of the timer queue with insert and remove shifts of the whole row.
module stq_queue #(
   parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
   localparam int QDEPTH = (NUM_TIMERS < stq_pkg::MAX_QDEPTH) ? NUM_TIMERS
                                                             : stq_pkg::MAX_QDEPTH,
   localparam int QIDX_W = $clog2(QDEPTH),
   localparam int QCNT_W = $clog2(QDEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  stq_pkg::qcmd_type              q_cmd,
   input  logic [QIDX_W-1:0]              q_pos,
   input  logic [QIDX_W-1:0]              q_rd_idx,
   output logic [stq_pkg::ID_W-1:0]       q_rd_id,
   output logic [stq_pkg::EXP_W-1:0]      q_rd_exp,
   output logic [QCNT_W-1:0]              q_count
);

   logic [stq_pkg::ID_W-1:0]  ids_ff [QDEPTH];
   logic [stq_pkg::EXP_W-1:0] exp_ff [QDEPTH];
   logic [QCNT_W-1:0]         count_ff;
   logic [QCNT_W-1:0]         count_in;

   // Each cell looks only at its own neighbors.
   for (genvar j = 0; j < QDEPTH; j++) begin : g_cell
      always_ff @(posedge clock) begin
         case (q_cmd.op)
            stq_pkg::QOP_INSERT: begin
               if (q_pos == QIDX_W'(j)) begin
                  ids_ff[j] <= q_cmd.id;
                  exp_ff[j] <= q_cmd.expiry;
               end else if (q_pos < QIDX_W'(j)) begin
                  if (j > 0) begin
                     ids_ff[j] <= ids_ff[(j > 0) ? j - 1 : 0];
                     exp_ff[j] <= exp_ff[(j > 0) ? j - 1 : 0];
                  end
               end
            end
            stq_pkg::QOP_REMOVE: begin
               if (q_pos <= QIDX_W'(j) && j < QDEPTH - 1) begin
                  ids_ff[j] <= ids_ff[(j < QDEPTH - 1) ? j + 1 : j];
                  exp_ff[j] <= exp_ff[(j < QDEPTH - 1) ? j + 1 : j];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (q_cmd.op)
         stq_pkg::QOP_INSERT: count_in = count_ff + QCNT_W'(1);
         stq_pkg::QOP_REMOVE: count_in = count_ff - QCNT_W'(1);
         default:             count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign q_rd_id = ids_ff[q_rd_idx];
   assign q_rd_exp = exp_ff[q_rd_idx];
   assign q_count = count_ff;

endmodule

// ----- design/stq_ctrl.sv -----
// Sequencer of the timer queue: timer table, queue walks and result register.
module stq_ctrl #(
   parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF,
   localparam int QDEPTH = (NUM_TIMERS < stq_pkg::MAX_QDEPTH) ? NUM_TIMERS
                                                             : stq_pkg::MAX_QDEPTH,
   localparam int QIDX_W = $clog2(QDEPTH),
   localparam int QCNT_W = $clog2(QDEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  stq_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output stq_pkg::rsp_type           rsp_data,
   input  logic [stq_pkg::EXP_W-1:0]  offset_ticks,
   output stq_pkg::alu_req_type       alu_req,
   input  stq_pkg::alu_rsp_type       alu_rsp,
   output stq_pkg::qcmd_type          q_cmd,
   output logic [QIDX_W-1:0]          q_pos,
   output logic [QIDX_W-1:0]          q_rd_idx,
   input  logic [stq_pkg::ID_W-1:0]   q_rd_id,
   input  logic [stq_pkg::EXP_W-1:0]  q_rd_exp,
   input  logic [QCNT_W-1:0]          q_count
);

   localparam logic [stq_pkg::ID_W:0] ID_LIMIT = (stq_pkg::ID_W + 1)'(QDEPTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SET_CHK,
      ST_REM_SCAN,
      ST_SET_ADD,
      ST_INS_SCAN,
      ST_TICK_ADD,
      ST_TICK_CHK,
      ST_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [1:0]                op_ff, op_in;
   logic [stq_pkg::ID_W-1:0]  id_ff, id_in;
   logic [stq_pkg::EXP_W-1:0] arg_ff, arg_in;
   logic [stq_pkg::EXP_W-1:0] key_ff, key_in;
   logic [QCNT_W-1:0]         idx_ff, idx_in;
   logic                      wp_ff, wp_in;
   logic                      hold_valid_ff, hold_valid_in;
   logic [stq_pkg::ID_W-1:0]  hold_id_ff, hold_id_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   stq_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic                      pending_ff [QDEPTH];
   logic [stq_pkg::EXP_W-1:0] stored_ff [QDEPTH];

   logic                      pend_we;
   logic [QIDX_W-1:0]         pend_widx;
   logic                      pend_wval;
   logic                      st_we;
   logic [QIDX_W-1:0]         tidx;
   logic [QIDX_W-1:0]         req_tidx;
   logic                      req_id_ok;
   logic                      slot_free;
   logic                      fire;

   assign tidx = id_ff[QIDX_W-1:0];
   assign req_tidx = req_data.timer_id[QIDX_W-1:0];
   assign req_id_ok = ({1'b0, req_data.timer_id} < ID_LIMIT);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      id_in = id_ff;
      arg_in = arg_ff;
      key_in = key_ff;
      idx_in = idx_ff;
      wp_in = wp_ff;
      hold_valid_in = hold_valid_ff;
      hold_id_in = hold_id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      pend_we = 1'b0;
      pend_widx = tidx;
      pend_wval = 1'b0;
      st_we = 1'b0;
      alu_req.a = arg_ff;
      alu_req.b = offset_ticks;
      alu_req.sub = 1'b0;
      q_cmd.op = stq_pkg::QOP_NONE;
      q_cmd.id = id_ff;
      q_cmd.expiry = key_ff;
      q_pos = idx_ff[QIDX_W-1:0];
      q_rd_idx = idx_ff[QIDX_W-1:0];
      fire = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in = req_data.opcode;
               id_in = req_data.timer_id;
               arg_in = (req_data.opcode == stq_pkg::OP_TICK) ? req_data.now
                                                              : req_data.expires;
               wp_in = 1'b0;
               hold_valid_in = 1'b0;
               idx_in = '0;
               case (req_data.opcode)
                  stq_pkg::OP_SET: begin
                     state_in = req_id_ok ? ST_SET_CHK : ST_EMIT;
                  end
                  stq_pkg::OP_DEL: begin
                     if (req_id_ok && pending_ff[req_tidx]) begin
                        pend_we = 1'b1;
                        pend_widx = req_tidx;
                        pend_wval = 1'b0;
                        wp_in = 1'b1;
                        state_in = ST_REM_SCAN;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  stq_pkg::OP_TICK: begin
                     state_in = ST_TICK_ADD;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_SET_CHK: begin
            // Same stored expiry as the raw request leaves the queue alone.
            alu_req.a = stored_ff[tidx];
            alu_req.b = arg_ff;
            alu_req.sub = 1'b1;
            if (pending_ff[tidx]) begin
               wp_in = 1'b1;
               state_in = alu_rsp.zero ? ST_EMIT : ST_REM_SCAN;
            end else begin
               state_in = ST_SET_ADD;
            end
         end
         ST_REM_SCAN: begin
            if (idx_ff == q_count || q_rd_id == id_ff) begin
               if (idx_ff != q_count) begin
                  q_cmd.op = stq_pkg::QOP_REMOVE;
               end
               state_in = (op_ff == stq_pkg::OP_SET) ? ST_SET_ADD : ST_EMIT;
            end else begin
               idx_in = idx_ff + QCNT_W'(1);
            end
         end
         ST_SET_ADD: begin
            alu_req.a = arg_ff;
            alu_req.b = offset_ticks;
            key_in = alu_rsp.sum;
            st_we = 1'b1;
            pend_we = 1'b1;
            pend_wval = 1'b1;
            idx_in = '0;
            state_in = (q_count >= QCNT_W'(QDEPTH)) ? ST_EMIT : ST_INS_SCAN;
         end
         ST_INS_SCAN: begin
            // Carry set means the new key is not below the entry: walk past it.
            alu_req.a = key_ff;
            alu_req.b = q_rd_exp;
            alu_req.sub = 1'b1;
            if (idx_ff != q_count && alu_rsp.carry) begin
               idx_in = idx_ff + QCNT_W'(1);
            end else begin
               q_cmd.op = stq_pkg::QOP_INSERT;
               state_in = ST_EMIT;
            end
         end
         ST_TICK_ADD: begin
            alu_req.a = arg_ff;
            alu_req.b = offset_ticks;
            key_in = alu_rsp.sum;
            state_in = ST_TICK_CHK;
         end
         ST_TICK_CHK: begin
            q_rd_idx = '0;
            q_pos = '0;
            alu_req.a = q_rd_exp;
            alu_req.b = key_ff;
            alu_req.sub = 1'b1;
            fire = (q_count != '0) && (alu_rsp.zero || alu_rsp.sum[stq_pkg::EXP_W-1]);
            if (fire) begin
               // The previous pop goes out now; the newest one waits for its last flag.
               if (!hold_valid_ff || slot_free) begin
                  q_cmd.op = stq_pkg::QOP_REMOVE;
                  pend_we = 1'b1;
                  pend_widx = q_rd_id[QIDX_W-1:0];
                  pend_wval = 1'b0;
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in.was_pending = 1'b0;
                     rsp_data_in.fired_valid = 1'b1;
                     rsp_data_in.fired_id = hold_id_ff;
                     rsp_data_in.last = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_id_in = q_rd_id;
               end
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.was_pending = wp_ff;
               rsp_data_in.fired_valid = hold_valid_ff;
               rsp_data_in.fired_id = hold_valid_ff ? hold_id_ff : '0;
               rsp_data_in.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
         for (int i = 0; i < QDEPTH; i++) begin
            pending_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
         if (pend_we) begin
            pending_ff[pend_widx] <= pend_wval;
         end
      end
      op_ff <= op_in;
      id_ff <= id_in;
      arg_ff <= arg_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      wp_ff <= wp_in;
      hold_id_ff <= hold_id_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stored_ff[tidx] <= alu_rsp.sum;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ----- design/sorted_timer_queue_core.sv -----
// Top level of the sorted timer queue: sleep offset register and block wiring.
//
// The block keeps up to 16 timers in a queue sorted by a 32-bit expiry tick and
// works on one transaction at a time; req_ready is high only while it waits for
// work. A set on a timer that is not pending checks the timer table, forms the
// new expiry, walks the queue to the insert point and then loads the result. A
// set that moves a pending timer first walks the queue to find and remove it,
// then forms the new expiry and walks again to the new insert point. A set
// that hits the same expiry shortcut loads its result straight after the check.
// A delete of a pending timer walks the queue to find and remove it; any other
// delete, a set with an id out of range and the unused opcode go straight to
// the result. A tick forms its threshold, then pops the expired timers in turn
// and stalls while the result side cannot take them. The single shared 32-bit
// adder and comparator serves the sequencer with one compare or one sum per
// cycle while it walks the queue one entry per cycle. Removal and insertion
// shift the whole entry row together. Each set or delete returns one rsp
// transaction; a tick returns one per expired timer with last set on the final
// one, or a single empty transaction when nothing fired. A result waits in an
// output register, so the next request can be taken while it is still
// unclaimed. The sleep offset is written through the csr channel, which is
// always ready; it is scaled to ticks when written, and must only be changed
// while the block is idle.
module sorted_timer_queue_core #(
   parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  stq_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output stq_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [stq_pkg::OFS_W-1:0] csr_data
);

   localparam int QDEPTH = (NUM_TIMERS < stq_pkg::MAX_QDEPTH) ? NUM_TIMERS
                                                             : stq_pkg::MAX_QDEPTH;
   localparam int QIDX_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);
   localparam logic [stq_pkg::EXP_W-1:0] TPS = stq_pkg::EXP_W'(stq_pkg::TICKS_PER_SEC);

   logic [stq_pkg::EXP_W-1:0] offset_ticks_ff, offset_ticks_in;
   stq_pkg::alu_req_type      alu_req;
   stq_pkg::alu_rsp_type      alu_rsp;
   stq_pkg::qcmd_type         q_cmd;
   logic [QIDX_W-1:0]         q_pos;
   logic [QIDX_W-1:0]         q_rd_idx;
   logic [stq_pkg::ID_W-1:0]  q_rd_id;
   logic [stq_pkg::EXP_W-1:0] q_rd_exp;
   logic [QCNT_W-1:0]         q_count;

   assign csr_ready = 1'b1;

   // The offset is kept in ticks, wrapped to 32 bits like every expiry.
   always_comb begin
      offset_ticks_in = offset_ticks_ff;
      if (csr_valid) begin
         offset_ticks_in = {{(stq_pkg::EXP_W - stq_pkg::OFS_W){1'b0}}, csr_data} * TPS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ticks_ff <= '0;
      end else begin
         offset_ticks_ff <= offset_ticks_in;
      end
   end

   stq_ctrl #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .offset_ticks(offset_ticks_ff),
      .alu_req(alu_req),
      .alu_rsp(alu_rsp),
      .q_cmd(q_cmd),
      .q_pos(q_pos),
      .q_rd_idx(q_rd_idx),
      .q_rd_id(q_rd_id),
      .q_rd_exp(q_rd_exp),
      .q_count(q_count)
   );

   stq_alu u_alu (
      .alu_req(alu_req),
      .alu_rsp(alu_rsp)
   );

   stq_queue #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .q_cmd(q_cmd),
      .q_pos(q_pos),
      .q_rd_idx(q_rd_idx),
      .q_rd_id(q_rd_id),
      .q_rd_exp(q_rd_exp),
      .q_count(q_count)
   );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the sorted timer queue core, with its own timer queue predictor.
module testbench;

   // Opcode 3 has no meaning in the block. It must change nothing and still
   // return one empty result transaction.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int TIMER_COUNT = stq_pkg::NUM_TIMERS_DEF;
   // Idle time at the end of the run; it covers even a set with a full queue.
   localparam int DRAIN_CYCLES = 60;

   // The receiver moves between these stall patterns, picked at random.
   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_RANDOM,
      FLOW_SPARSE
   } flow_type;

   // One entry of the predicted queue, kept sorted by expiry.
   typedef struct packed {
      logic [stq_pkg::ID_W-1:0]  id;
      logic [stq_pkg::EXP_W-1:0] expiry;
   } slot_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   stq_pkg::req_type          req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   stq_pkg::rsp_type          rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [stq_pkg::OFS_W-1:0] csr_data = '0;

   // Predictor state: the sleep offset as written, the sorted queue, and the
   // pending flag and stored expiry of every timer.
   logic [stq_pkg::OFS_W-1:0] model_offset_sec = '0;
   slot_type                  armed_order[$];
   logic                      armed [TIMER_COUNT];
   logic [stq_pkg::EXP_W-1:0] armed_expiry [TIMER_COUNT];

   // Request transactions waiting for the driver, and the result transactions
   // that the accepted requests are predicted to produce, oldest first.
   stq_pkg::req_type pending_req[$];
   stq_pkg::rsp_type awaited_rsp[$];

   // Generator state. The generator runs ahead of the block, so it keeps its
   // own notion of the current tick, the offset and the last requested expiries.
   logic [stq_pkg::EXP_W-1:0] gen_clock = '0;
   logic [stq_pkg::EXP_W-1:0] gen_offset_ticks = '0;
   logic [stq_pkg::EXP_W-1:0] gen_last_exp [TIMER_COUNT];

   int mismatch_count = 0;
   int accepted_items = 0;
   int checked_rsp = 0;
   int fired_total = 0;
   int most_fired = 0;
   int offsets_written = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_phase = 0;
   flow_type stall_mode = FLOW_FREE;

   sorted_timer_queue_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Prints one line per mismatch and counts every one of them.
   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("%0t: %s", $time, what);
   endtask

   // The sleep offset scaled to ticks. The product stays below 2^31, so the
   // 32-bit result is exact.
   function automatic logic [stq_pkg::EXP_W-1:0] offset_ticks();
      return stq_pkg::EXP_W'(model_offset_sec) * stq_pkg::EXP_W'(stq_pkg::TICKS_PER_SEC);
   endfunction

   function automatic void unlink_timer(logic [stq_pkg::ID_W-1:0] id);
      for (int i = 0; i < armed_order.size(); i++) begin
         if (armed_order[i].id == id) begin
            armed_order.delete(i);
            return;
         end
      end
   endfunction

   // Applies one accepted request transaction to the predicted state and
   // appends the result transactions it must produce.
   function automatic void advance_timer_model(stq_pkg::req_type item);
      stq_pkg::rsp_type          outcome;
      logic [stq_pkg::EXP_W-1:0] due;
      logic [stq_pkg::EXP_W-1:0] diff;
      int                        pos;
      int                        fired;
      outcome = '0;
      outcome.last = 1'b1;
      fired = 0;
      case (item.opcode)
         stq_pkg::OP_SET: begin
            // The same expiry shortcut compares the stored expiry, offset
            // included, against the raw request value.
            if (armed[item.timer_id] && armed_expiry[item.timer_id] == item.expires) begin
               outcome.was_pending = 1'b1;
            end else begin
               if (armed[item.timer_id]) begin
                  unlink_timer(item.timer_id);
                  outcome.was_pending = 1'b1;
               end
               due = item.expires + offset_ticks();
               armed_expiry[item.timer_id] = due;
               // A new entry goes behind every entry with an equal expiry.
               pos = 0;
               while (pos < armed_order.size() && armed_order[pos].expiry <= due) begin
                  pos++;
               end
               armed_order.insert(pos, slot_type'{id: item.timer_id, expiry: due});
               armed[item.timer_id] = 1'b1;
            end
            awaited_rsp.push_back(outcome);
         end
         stq_pkg::OP_DEL: begin
            // The stored expiry survives a delete; only the pending flag drops.
            if (armed[item.timer_id]) begin
               unlink_timer(item.timer_id);
               armed[item.timer_id] = 1'b0;
               outcome.was_pending = 1'b1;
            end
            awaited_rsp.push_back(outcome);
         end
         stq_pkg::OP_TICK: begin
            due = item.now + offset_ticks();
            while (armed_order.size() > 0) begin
               // The head has expired when its distance to now, read as a
               // signed number, is zero or negative.
               diff = armed_order[0].expiry - due;
               if (diff != '0 && !diff[stq_pkg::EXP_W-1]) begin
                  break;
               end
               outcome = '0;
               outcome.fired_valid = 1'b1;
               outcome.fired_id = armed_order[0].id;
               armed[armed_order[0].id] = 1'b0;
               void'(armed_order.pop_front());
               awaited_rsp.push_back(outcome);
               fired++;
            end
            if (fired == 0) begin
               outcome = '0;
               outcome.last = 1'b1;
               awaited_rsp.push_back(outcome);
            end else begin
               outcome = awaited_rsp.pop_back();
               outcome.last = 1'b1;
               awaited_rsp.push_back(outcome);
            end
            fired_total += fired;
            if (fired > most_fired) begin
               most_fired = fired;
            end
         end
         default: begin
            awaited_rsp.push_back(outcome);
         end
      endcase
   endfunction

   // Request driver. A new transaction is loaded when the slot is empty or
   // its transaction is taken at this edge, so valid never drops while it waits.
   // The sender works in bursts of random length separated by random gaps;
   // a gap of zero lets several bursts run back to back with no idling.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_timer_model(req_data);
            accepted_items++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               req_data <= pending_req.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every accepted result transaction is checked field by
   // field against the oldest prediction. Ready follows a pattern that changes
   // between always ready, random stalls and a sparse, regular ready.
   always @(posedge clock) begin : rsp_monitor
      stq_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("result transaction arrived with nothing expected");
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.was_pending !== want.was_pending) begin
                  report_mismatch($sformatf("result %0d: was_pending is %0b, expected %0b",
                     checked_rsp, rsp_data.was_pending, want.was_pending));
               end
               if (rsp_data.fired_valid !== want.fired_valid) begin
                  report_mismatch($sformatf("result %0d: fired_valid is %0b, expected %0b",
                     checked_rsp, rsp_data.fired_valid, want.fired_valid));
               end
               if (rsp_data.fired_id !== want.fired_id) begin
                  report_mismatch($sformatf("result %0d: fired_id is %0d, expected %0d",
                     checked_rsp, rsp_data.fired_id, want.fired_id));
               end
               if (rsp_data.last !== want.last) begin
                  report_mismatch($sformatf("result %0d: last is %0b, expected %0b",
                     checked_rsp, rsp_data.last, want.last));
               end
               checked_rsp++;
            end
         end
         stall_phase++;
         if (stall_phase % 48 == 0) begin
            stall_mode = flow_type'($urandom_range(0, 2));
         end
         case (stall_mode)
            FLOW_FREE: begin
               rsp_ready <= 1'b1;
            end
            FLOW_RANDOM: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_ready <= (stall_phase % 4 == 0);
            end
         endcase
      end
   end

   function automatic void queue_item(logic [1:0] opcode, logic [stq_pkg::ID_W-1:0] id,
                                      logic [stq_pkg::EXP_W-1:0] expires,
                                      logic [stq_pkg::EXP_W-1:0] now);
      stq_pkg::req_type item;
      item.opcode = opcode;
      item.timer_id = id;
      item.expires = expires;
      item.now = now;
      pending_req.push_back(item);
   endfunction

   // Holds the stimulus until the driver has nothing left and every
   // predicted result has been taken.
   task automatic wait_until_idle();
      while (pending_req.size() > 0 || req_valid || awaited_rsp.size() > 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Writes the sleep offset while the block is idle.
   task automatic write_sleep_offset(logic [stq_pkg::OFS_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_offset_sec = value;
      gen_offset_ticks = offset_ticks();
      offsets_written++;
      repeat (2) @(posedge clock);
   endtask

   // Random traffic that looks like real timer use: timers are armed a little
   // ahead of a running tick count, re-armed, deleted and then expired as the
   // tick count advances. Now and then a timer is armed anywhere in the 32-bit
   // range, a tick lands on a random count, or all timers are armed at once
   // and expired by a single tick.
   task automatic random_phase(int count);
      int                        left;
      int                        pick;
      logic [stq_pkg::ID_W-1:0]  id;
      logic [stq_pkg::EXP_W-1:0] target;
      left = count;
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         id = stq_pkg::ID_W'($urandom);
         if (pick < 5) begin
            for (int i = 0; i < TIMER_COUNT; i++) begin
               target = gen_clock + stq_pkg::EXP_W'($urandom_range(0, 300));
               gen_last_exp[i] = target;
               queue_item(stq_pkg::OP_SET, stq_pkg::ID_W'(i), target, $urandom);
            end
            gen_clock += stq_pkg::EXP_W'(300);
            queue_item(stq_pkg::OP_TICK, stq_pkg::ID_W'($urandom), $urandom, gen_clock);
            left -= TIMER_COUNT + 1;
         end else if (pick < 40) begin
            if ($urandom_range(0, 9) == 0) begin
               target = $urandom;
            end else begin
               target = gen_clock + stq_pkg::EXP_W'($urandom_range(0, 1500));
            end
            gen_last_exp[id] = target;
            queue_item(stq_pkg::OP_SET, id, target, $urandom);
            left--;
         end else if (pick < 48) begin
            // Asking for the stored expiry of a pending timer hits the shortcut.
            queue_item(stq_pkg::OP_SET, id, gen_last_exp[id] + gen_offset_ticks, $urandom);
            left--;
         end else if (pick < 63) begin
            queue_item(stq_pkg::OP_DEL, id, $urandom, $urandom);
            left--;
         end else if (pick < 96) begin
            gen_clock += stq_pkg::EXP_W'($urandom_range(0, 400));
            if ($urandom_range(0, 15) == 0) begin
               queue_item(stq_pkg::OP_TICK, id, $urandom, $urandom);
            end else begin
               queue_item(stq_pkg::OP_TICK, id, $urandom, gen_clock);
            end
            left--;
         end else begin
            queue_item(OP_UNUSED, id, $urandom, $urandom);
            left--;
         end
      end
   endtask

   initial begin
      foreach (armed[i]) begin
         armed[i] = 1'b0;
         armed_expiry[i] = '0;
         gen_last_exp[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the offset at its reset value of zero.
      // A tick on an empty queue fires nothing.
      queue_item(stq_pkg::OP_TICK, '0, '0, '0);
      // Arm the extremes of the expiry range and one ordinary timer.
      queue_item(stq_pkg::OP_SET, 4'd0, '0, '0);
      queue_item(stq_pkg::OP_SET, 4'd15, '1, '1);
      queue_item(stq_pkg::OP_SET, 4'd5, 32'd100, '0);
      // Same expiry again on a pending timer: nothing moves.
      queue_item(stq_pkg::OP_SET, 4'd5, 32'd100, '0);
      // A new expiry on a pending timer moves it.
      queue_item(stq_pkg::OP_SET, 4'd5, 32'd50, '0);
      // Equal expiries keep their arrival order.
      queue_item(stq_pkg::OP_SET, 4'd7, 32'd100, '0);
      queue_item(stq_pkg::OP_SET, 4'd9, 32'd100, '0);
      // Delete a pending timer, the same one again, and one never armed.
      queue_item(stq_pkg::OP_DEL, 4'd7, '0, '0);
      queue_item(stq_pkg::OP_DEL, 4'd7, '0, '0);
      queue_item(stq_pkg::OP_DEL, 4'd3, '0, '0);
      // The unused opcode with every field bit set.
      queue_item(OP_UNUSED, '1, '1, '1);
      // Pops stop at the first head that lies in the future.
      queue_item(stq_pkg::OP_TICK, '1, '1, 32'd99);
      // A zero distance fires, and the top of the range reads as the past.
      queue_item(stq_pkg::OP_TICK, '0, '0, 32'd100);
      // Around the sign boundary of the distance.
      queue_item(stq_pkg::OP_SET, 4'd2, 32'h8000_0000, '0);
      queue_item(stq_pkg::OP_SET, 4'd3, 32'h7FFF_FFFF, '0);
      queue_item(stq_pkg::OP_TICK, '0, '0, '0);
      queue_item(stq_pkg::OP_TICK, '0, '0, 32'h7FFF_FFFF);
      // The stored expiry is kept after a delete, yet a later set still queues.
      queue_item(stq_pkg::OP_SET, 4'd2, '0, '0);
      queue_item(stq_pkg::OP_DEL, 4'd2, '0, '0);
      queue_item(stq_pkg::OP_SET, 4'd2, '0, '0);
      queue_item(stq_pkg::OP_TICK, '0, '0, '1);
      queue_item(stq_pkg::OP_TICK, '0, '0, '0);
      wait_until_idle();

      // Random phases, with the offset rewritten before all but the first. The sender holds off between
      // phases until every expected result has arrived.
      gen_clock = $urandom;
      random_phase(100);
      wait_until_idle();

      write_sleep_offset('1);
      gen_clock = 32'hFFFF_F000;
      random_phase(100);
      wait_until_idle();

      write_sleep_offset(stq_pkg::OFS_W'($urandom));
      gen_clock = $urandom;
      random_phase(100);
      wait_until_idle();

      write_sleep_offset('0);
      gen_clock = $urandom;
      random_phase(100);
      wait_until_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d request transactions under %0d offset settings; %0d results checked.",
               accepted_items, offsets_written + 1, checked_rsp);
      $display("Ticks expired %0d timers in all, at most %0d in one transaction.",
               fired_total, most_fired);
      if (mismatch_count == 0) begin
         $display("sorted_timer_queue_core: match");
      end else begin
         $display("sorted_timer_queue_core: mismatch");
      end
      $finish;
   end

   // Watchdog: a stuck handshake or a lost result ends the run here.
   initial begin
      #5_000_000;
      $display("sorted_timer_queue_core: mismatch");
      $finish;
   end

endmodule
